FILE: hw/rtl/tracking_overlap_metrics_assert.svh
// Assertion macros for the tracking overlap metrics block.
// No dependencies; included by the top level.
`ifndef TRACKING_OVERLAP_METRICS_ASSERT_SVH
`define TRACKING_OVERLAP_METRICS_ASSERT_SVH
`ifndef SYNTHESIS
`define TOM_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TOM_ASSERT_ONEHOT(label, clk, rst_n, en, vec, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) en |-> $onehot(vec)) \
    else $error(msg);
`else
`define TOM_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define TOM_ASSERT_ONEHOT(label, clk, rst_n, en, vec, msg)
`endif
`endif

FILE: hw/rtl/tom_pkg.sv
// Shared types and constants for the tracking overlap metrics block.
// No dependencies.
package tom_pkg;
  localparam int unsigned THRESH_BITS = 17;
  localparam int unsigned DIST_BITS   = 18;
  localparam int unsigned SUM_BITS    = 40;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 17'd66;
  localparam logic [DIST_BITS-1:0]   DIST_MAX     = 18'h3FFFF;
  localparam logic [SUM_BITS-1:0]    SUM_MAX      = 40'hFF_FFFF_FFFF;

  // frame class handed from front to back
  typedef struct packed {
    logic miss;
    logic zero_union;
  } tom_class_t;
endpackage

FILE: hw/rtl/tom_front.sv
// Front end: geometry of one frame (spans, areas, centre deltas).
// Depends on tom_pkg.
module tom_front import tom_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COORD_BITS-1:0]     tx, ty, tw, th, hx, hy, hw, hh,
  input  logic                      present,
  output logic                      q_valid,
  input  logic                      q_ready,
  output tom_class_t                q_cls,
  output logic [2*COORD_BITS+1:0]   q_inter,
  output logic [2*COORD_BITS+1:0]   q_union,
  output logic [2*COORD_BITS+2:0]   q_dsq
);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned AB = 2*CB+2;

  // stage 0: spans and centre deltas; stage 1: products
  logic              s0_v_r, s1_v_r;
  logic              s0_miss_r, s1_miss_r;
  logic [CB:0]       sx_r, sy_r, dx_r, dy_r;
  logic [CB-1:0]     tw_r, th_r, hw_r, hh_r;
  logic [AB-1:0]     inter_r, union_r;
  logic [AB:0]       dsq_r;
  logic [CB:0]       lox, loy, hix, hiy, ctx, cty, chx, chy;
  logic [2*CB-1:0]   at, ah, ip;
  logic [AB-1:0]     dxq, dyq;

  assign q_valid = s1_v_r;
  assign in_ready = !s0_v_r || !s1_v_r || q_ready;
  wire s1_take = s0_v_r && (!s1_v_r || q_ready);

  always_comb begin
    lox = ({1'b0,tx} > {1'b0,hx}) ? {1'b0,tx} : {1'b0,hx};
    loy = ({1'b0,ty} > {1'b0,hy}) ? {1'b0,ty} : {1'b0,hy};
    hix = ({1'b0,tx}+{1'b0,tw} < {1'b0,hx}+{1'b0,hw}) ? {1'b0,tx}+{1'b0,tw}
                                                      : {1'b0,hx}+{1'b0,hw};
    hiy = ({1'b0,ty}+{1'b0,th} < {1'b0,hy}+{1'b0,hh}) ? {1'b0,ty}+{1'b0,th}
                                                      : {1'b0,hy}+{1'b0,hh};
    ctx = {1'b0,tx} + {2'b0,tw[CB-1:1]};
    cty = {1'b0,ty} + {2'b0,th[CB-1:1]};
    chx = {1'b0,hx} + {2'b0,hw[CB-1:1]};
    chy = {1'b0,hy} + {2'b0,hh[CB-1:1]};
    at  = {{CB{1'b0}}, tw_r} * {{CB{1'b0}}, th_r};
    ah  = {{CB{1'b0}}, hw_r} * {{CB{1'b0}}, hh_r};
    ip  = {{CB{1'b0}}, sx_r[CB-1:0]} * {{CB{1'b0}}, sy_r[CB-1:0]};
    // squares need the full 2*CB+2 bits
    dxq = {{(CB+1){1'b0}}, dx_r} * {{(CB+1){1'b0}}, dx_r};
    dyq = {{(CB+1){1'b0}}, dy_r} * {{(CB+1){1'b0}}, dy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) s0_v_r <= 1'b1;
      else if (s1_take)         s0_v_r <= 1'b0;
      if (s1_take)              s1_v_r <= 1'b1;
      else if (q_ready)         s1_v_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s0_miss_r <= !present;
      sx_r <= (hix > lox) ? hix - lox : '0;
      sy_r <= (hiy > loy) ? hiy - loy : '0;
      dx_r <= (ctx > chx) ? ctx - chx : chx - ctx;
      dy_r <= (cty > chy) ? cty - chy : chy - cty;
      tw_r <= tw; th_r <= th; hw_r <= hw; hh_r <= hh;
    end
    if (s1_take) begin
      s1_miss_r <= s0_miss_r;
      inter_r <= {2'b0, ip};
      union_r <= {2'b0, at} + {2'b0, ah} - {2'b0, ip};
      dsq_r   <= {1'b0, dxq} + {1'b0, dyq};
    end
  end

  assign q_cls.miss       = s1_miss_r;
  assign q_cls.zero_union = (union_r == '0);
  assign q_inter = inter_r;
  assign q_union = union_r;
  assign q_dsq   = dsq_r;
endmodule

FILE: hw/rtl/tom_back.sv
// Back end: serial IoU divide, serial square root, counters, result register.
// Depends on tom_pkg.
module tom_back import tom_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [THRESH_BITS-1:0]   thresh,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  tom_class_t               q_cls,
  input  logic [2*COORD_BITS+1:0]  q_inter,
  input  logic [2*COORD_BITS+1:0]  q_union,
  input  logic [2*COORD_BITS+2:0]  q_dsq,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [THRESH_BITS-1:0]   out_overlap_ratio,
  output logic                     out_is_match,
  output logic                     out_is_mismatch,
  output logic                     out_is_miss,
  output logic [DIST_BITS-1:0]     out_centre_distance,
  output logic [COUNT_BITS-1:0]    frames_seen, matches_seen, mismatches_seen, misses_seen,
  output logic [SUM_BITS-1:0]      out_distance_total
);
  localparam int unsigned AB = 2*COORD_BITS+2;
  localparam int unsigned RB = AB + 16;         // inter << 16 width (quotient bits)
  localparam int unsigned VB = AB + 9;          // dsq * 256
  localparam int unsigned SQB = (VB+1)/2 + 1;   // root bits
  localparam int unsigned NB = $clog2(RB+1);
  localparam int unsigned DBG = (SQB > DIST_BITS) ? SQB : DIST_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  localparam logic [2:0] ST_IDLE = 3'd0, ST_DIV = 3'd1, ST_DEC = 3'd2,
                         ST_SQRT = 3'd3, ST_DONE = 3'd4;

  logic [2:0]      st_r, st_nxt;
  logic [NB-1:0]   cnt_r;
  logic [RB-1:0]   num_r, quo_r;
  logic [AB:0]     rem_r;
  logic [AB-1:0]   den_r;
  logic [VB+1:0]   val_r, root_r, bit_r;
  logic            miss_r;
  logic [COUNT_BITS-1:0] fc_r, mc_r, xc_r, sc_r;
  logic [SUM_BITS-1:0]   sum_r;
  logic            full_r;
  logic [AB:0]     rem_sh;
  logic [VB+1:0]   trial;
  logic [THRESH_BITS-1:0] ratio;
  logic [DBG-1:0]  dist_w;
  logic [DIST_BITS-1:0] dist_sat;
  logic            is_match;

  assign out_empty = !full_r;
  assign q_ready = (st_r == ST_IDLE);
  assign rem_sh = {rem_r[AB-1:0], num_r[RB-1]};
  assign trial  = root_r + bit_r;
  // quotient never exceeds 65536
  assign ratio  = quo_r[THRESH_BITS-1:0];
  assign dist_w = DBG'(root_r);
  assign dist_sat = (dist_w > DBG'(DIST_MAX)) ? DIST_MAX : dist_w[DIST_BITS-1:0];
  // bit_r[0] marks a completed root, i.e. a match
  assign is_match = !miss_r && (root_r[VB+1] == 1'b0) && bit_r[0];

  function automatic logic [COUNT_BITS-1:0] sat(input logic [COUNT_BITS-1:0] v);
    sat = (v == CMAX) ? v : v + 1'b1;
  endfunction

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) st_nxt = (q_cls.miss || q_cls.zero_union) ? ST_DONE : ST_DIV;
      ST_DIV:  if (cnt_r == NB'(RB-1)) st_nxt = ST_DEC;
      ST_DEC:  st_nxt = (ratio >= thresh) ? ST_SQRT : ST_DONE;
      ST_SQRT: if (bit_r[VB+1:2] == '0) st_nxt = ST_DONE;
      ST_DONE: if (!full_r || out_pop) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      full_r <= 1'b0;
      fc_r <= '0; mc_r <= '0; xc_r <= '0; sc_r <= '0; sum_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_DONE && (!full_r || out_pop)) begin
        full_r <= 1'b1;
        fc_r <= sat(fc_r);
        out_is_miss <= miss_r;
        out_is_match <= is_match;
        out_is_mismatch <= !miss_r && !is_match;
        out_centre_distance <= is_match ? dist_sat : '0;
        out_overlap_ratio <= miss_r ? '0 : ratio;
        if (miss_r) sc_r <= sat(sc_r);
        else if (is_match) begin
          mc_r <= sat(mc_r);
          sum_r <= (sum_r > SUM_MAX - SUM_BITS'(dist_sat)) ? SUM_MAX
                                                           : sum_r + SUM_BITS'(dist_sat);
        end else begin
          xc_r <= sat(xc_r);
        end
      end else if (out_pop && full_r) begin
        full_r <= 1'b0;
      end
    end
    case (st_r)
      ST_IDLE: begin
        miss_r <= q_cls.miss;
        num_r  <= {q_inter, 16'd0};
        den_r  <= q_union;
        rem_r  <= '0;
        quo_r  <= '0;
        cnt_r  <= '0;
        val_r  <= {2'b0, q_dsq, 8'd0};
        root_r <= '0;
        bit_r  <= '0;
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        num_r <= {num_r[RB-2:0], 1'b0};
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= rem_sh - {1'b0, den_r};
          quo_r <= {quo_r[RB-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[RB-2:0], 1'b0};
        end
      end
      ST_DEC: begin
        // largest power of four below 2^VB (VB is odd)
        bit_r <= {3'b001, {(VB-1){1'b0}}};
      end
      ST_SQRT: begin
        if (val_r >= trial) begin
          val_r  <= val_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= (bit_r[VB+1:2] == '0) ? {{VB+1{1'b0}}, 1'b1} : bit_r >> 2;
      end
      default: ;
    endcase
  end

  assign frames_seen = fc_r;
  assign matches_seen = mc_r;
  assign mismatches_seen = xc_r;
  assign misses_seen = sc_r;
  assign out_distance_total = sum_r;
endmodule

FILE: hw/rtl/tracking_overlap_metrics.sv
// Top level of the tracking overlap metrics block.
// Depends on tom_pkg, tom_front, tom_back and the assertion macro header.
// The back end takes a transaction from the front in its idle state, runs RB
// divide steps (RB = 2*COORD_BITS+18, 42 at the defaults), decides against the
// threshold, runs COORD_BITS+6 square root steps on a match only (18 at the
// defaults) and then loads the result register; a miss or an empty union goes
// straight from the idle state to loading the result. The front registers each
// frame in its stage 0 and stage 1 and prepares the next frame while the back
// works; an unpopped result holds the back end. Counters saturate at all ones.
`include "tracking_overlap_metrics_assert.svh"
module tracking_overlap_metrics import tom_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [THRESH_BITS-1:0] cfg_iou_threshold,
  input  logic                   push,
  output logic                   full,
  input  logic [COORD_BITS-1:0]  in_truth_x, in_truth_y, in_truth_w, in_truth_h,
  input  logic [COORD_BITS-1:0]  in_hyp_x, in_hyp_y, in_hyp_w, in_hyp_h,
  input  logic                   in_hyp_present,
  output logic                   empty,
  input  logic                   pop,
  output logic [THRESH_BITS-1:0] out_overlap_ratio,
  output logic                   out_is_match,
  output logic                   out_is_mismatch,
  output logic                   out_is_miss,
  output logic [DIST_BITS-1:0]   out_centre_distance,
  output logic [COUNT_BITS-1:0]  out_frames_seen,
  output logic [COUNT_BITS-1:0]  out_matches_seen,
  output logic [COUNT_BITS-1:0]  out_mismatches_seen,
  output logic [COUNT_BITS-1:0]  out_misses_seen,
  output logic [SUM_BITS-1:0]    out_distance_total
);
  logic [THRESH_BITS-1:0] thresh_r;
  logic q_valid, q_ready, in_ready;
  tom_class_t q_cls;
  logic [2*COORD_BITS+1:0] q_inter, q_union;
  logic [2*COORD_BITS+2:0] q_dsq;
  logic [2:0] res_cls;
  logic dist_ok;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) thresh_r <= THRESH_RESET;
    else if (cfg_we) thresh_r <= cfg_iou_threshold;
  end

  assign full = !in_ready;

  tom_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .in_valid(push), .in_ready,
    .tx(in_truth_x), .ty(in_truth_y), .tw(in_truth_w), .th(in_truth_h),
    .hx(in_hyp_x), .hy(in_hyp_y), .hw(in_hyp_w), .hh(in_hyp_h),
    .present(in_hyp_present), .q_valid, .q_ready, .q_cls, .q_inter, .q_union, .q_dsq
  );

  tom_back #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .thresh(thresh_r), .q_valid, .q_ready, .q_cls, .q_inter, .q_union,
    .q_dsq, .out_empty(empty), .out_pop(pop), .out_overlap_ratio, .out_is_match,
    .out_is_mismatch, .out_is_miss, .out_centre_distance,
    .frames_seen(out_frames_seen), .matches_seen(out_matches_seen),
    .mismatches_seen(out_mismatches_seen), .misses_seen(out_misses_seen),
    .out_distance_total
  );

  // exactly one class per result; distance only on a match
  assign res_cls = {out_is_match, out_is_mismatch, out_is_miss};
  assign dist_ok = out_is_match || (out_centre_distance == '0);
  `TOM_ASSERT_ONEHOT(a_one_class, clk, rst_n, !empty, res_cls, "class not one-hot")
  `TOM_ASSERT_IMPL(a_dist_match, clk, rst_n, !empty |-> dist_ok, "distance without match")
  `TOM_ASSERT_IMPL(a_sum_mono, clk, rst_n, out_distance_total >= $past(out_distance_total), "sum fell")
endmodule
